// ===== src/rc5pwd_pkg.sv =====
`timescale 1ns / 1ps

package rc5pwd_pkg;

  // Field and register widths.
  localparam int WIDTH_W     = 16;
  localparam int UNIT_W      = 16;
  localparam int ROUND_W     = 4;
  localparam int LIMIT_W     = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int COMMAND_W   = 6;
  localparam int ADDRESS_W   = 5;
  localparam int OUT_DATA_W  = 16;

  // A rounded width can carry one bit above the measured width.
  localparam int ROUNDED_W = WIDTH_W + 1;

  // Register reset values.
  localparam logic [UNIT_W-1:0]  UNIT_TICKS_RESET = 16'd4000;
  localparam logic [ROUND_W-1:0] ROUND_LOG2_RESET = 4'd10;
  localparam logic [LIMIT_W-1:0] IDLE_LIMIT_RESET = 8'd20;

  // Default depth of the queue between the front and the back end.
  localparam int QUEUE_DEPTH = 2;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_UNIT_TICKS = 2'd0,
    REG_ROUND_LOG2 = 2'd1,
    REG_IDLE_LIMIT = 2'd2
  } cfg_reg_t;

  // Width class after division by the unit period.
  typedef enum logic [1:0] {
    CLS_FOUR  = 2'd0,
    CLS_SIX   = 2'd1,
    CLS_EIGHT = 2'd2,
    CLS_BAD   = 2'd3
  } width_cls_t;

  // Event kinds on the result stream.
  localparam logic EVT_FRAME  = 1'b0;
  localparam logic EVT_NO_KEY = 1'b1;

  // One classified item as it travels through the queue.
  typedef struct packed {
    logic       is_timeout;
    width_cls_t cls;
  } qitem_t;

endpackage

// ===== src/rc5pwd_front.sv =====
`timescale 1ns / 1ps

module rc5pwd_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_timeout,
  input  logic [rc5pwd_pkg::WIDTH_W-1:0]  in_width,
  input  logic [rc5pwd_pkg::UNIT_W-1:0]   unit_ticks,
  input  logic [rc5pwd_pkg::ROUND_W-1:0]  round_log2,
  output logic                            push_valid,
  output rc5pwd_pkg::qitem_t              push_item,
  input  logic                            queue_full
);
  import rc5pwd_pkg::*;

  localparam int DIV_STEPS = ROUNDED_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    F_IDLE  = 4'b0001,
    F_ROUND = 4'b0010,
    F_DIV   = 4'b0100,
    F_PUSH  = 4'b1000
  } front_state_t;

  front_state_t           state;
  front_state_t           state_next;
  logic                   tmo;
  logic [WIDTH_W-1:0]     width;
  logic [ROUNDED_W-1:0]   dvd;
  logic [UNIT_W-1:0]      rem;
  logic [STEP_W-1:0]      step;
  logic [ROUNDED_W-1:0]   quantum;
  logic [ROUNDED_W-1:0]   rounded;
  logic [UNIT_W:0]        trial;
  logic                   trial_ge;
  logic [UNIT_W:0]        trial_diff;

  // Map a quotient onto the width classes the decoder knows.
  function automatic width_cls_t classify(input logic [ROUNDED_W-1:0] q);
    width_cls_t c;
    begin
      if (q == ROUNDED_W'(4)) begin
        c = CLS_FOUR;
      end else if (q == ROUNDED_W'(6)) begin
        c = CLS_SIX;
      end else if (q == ROUNDED_W'(8)) begin
        c = CLS_EIGHT;
      end else begin
        c = CLS_BAD;
      end
      return c;
    end
  endfunction

  // Round the width to the nearest multiple of the quantum.
  assign quantum = ROUNDED_W'(1) << round_log2;
  assign rounded = ({1'b0, width} + (quantum >> 1)) & ~(quantum - ROUNDED_W'(1));

  // One restoring division step: bring in the next dividend bit and try the divisor.
  // A zero divisor always succeeds, so the quotient comes out all ones.
  assign trial      = {rem, dvd[ROUNDED_W-1]};
  assign trial_ge   = (trial >= {1'b0, unit_ticks});
  assign trial_diff = trial - {1'b0, unit_ticks};

  assign in_ready   = (state == F_IDLE);
  assign push_valid = (state == F_PUSH);
  assign push_item  = '{is_timeout: tmo, cls: classify(dvd)};

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: begin
        if (in_valid) begin
          state_next = F_ROUND;
        end
      end
      F_ROUND: begin
        state_next = tmo ? F_PUSH : F_DIV;
      end
      F_DIV: begin
        if (step == '0) begin
          state_next = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!queue_full) begin
          state_next = F_IDLE;
        end
      end
      default: begin
        state_next = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath: capture, round, then divide one quotient bit a cycle.
  always_ff @(posedge clk) begin
    if (state == F_IDLE && in_valid) begin
      tmo   <= in_timeout;
      width <= in_width;
    end
    if (state == F_ROUND) begin
      dvd  <= rounded;
      rem  <= '0;
      step <= STEP_W'(DIV_STEPS - 1);
    end else if (state == F_DIV) begin
      dvd  <= {dvd[ROUNDED_W-2:0], trial_ge};
      rem  <= trial_ge ? trial_diff[UNIT_W-1:0] : trial[UNIT_W-1:0];
      step <= step - STEP_W'(1);
    end
  end

endmodule

// ===== src/rc5pwd_queue.sv =====
`timescale 1ns / 1ps

module rc5pwd_queue #(
  parameter int DEPTH = rc5pwd_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  rc5pwd_pkg::qitem_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output rc5pwd_pkg::qitem_t head_item
);
  import rc5pwd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  qitem_t             mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Storage write.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== src/rc5pwd_back.sv =====
`timescale 1ns / 1ps

module rc5pwd_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                head_valid,
  input  rc5pwd_pkg::qitem_t                  head_item,
  output logic                                pop,
  input  logic [rc5pwd_pkg::LIMIT_W-1:0]      idle_limit,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_kind,
  output logic [rc5pwd_pkg::COMMAND_W-1:0]    out_command,
  output logic [rc5pwd_pkg::ADDRESS_W-1:0]    out_address,
  output logic                                out_toggle
);
  import rc5pwd_pkg::*;

  localparam int SHIFT_W = 16;
  localparam int COUNT_W = 5;
  localparam logic [COUNT_W-1:0] SHORT_FRAME = COUNT_W'(13);
  localparam logic [COUNT_W-1:0] FULL_FRAME  = COUNT_W'(14);

  typedef enum logic [4:0] {
    P_IDLE  = 5'b00001,
    P_SYNC  = 5'b00010,
    P_ONE   = 5'b00100,
    P_ZZ    = 5'b01000,
    P_ERROR = 5'b10000
  } phase_t;

  phase_t               phase;
  phase_t               phase_next;
  logic [SHIFT_W-1:0]   bit_shift;
  logic [SHIFT_W-1:0]   bit_shift_next;
  logic [COUNT_W-1:0]   bit_count;
  logic [COUNT_W-1:0]   bit_count_next;
  logic [LIMIT_W-1:0]   idle_count;
  logic [LIMIT_W-1:0]   idle_count_next;
  logic [LIMIT_W-1:0]   idle_inc;
  logic                 frame_end;
  logic                 out_load;
  logic                 out_kind_next;
  logic [COMMAND_W-1:0] out_command_next;
  logic [ADDRESS_W-1:0] out_address_next;
  logic                 out_toggle_next;

  // Bit count grows by n and sticks at its top value.
  function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] c,
                                                 input logic [1:0] n);
    logic [COUNT_W:0] sum;
    begin
      sum = {1'b0, c} + (COUNT_W + 1)'(n);
      return sum[COUNT_W] ? {COUNT_W{1'b1}} : sum[COUNT_W-1:0];
    end
  endfunction

  // Take the next item only when the result register can accept a result.
  assign pop      = head_valid && (!out_valid || out_ready);
  assign idle_inc = (idle_count == {LIMIT_W{1'b1}}) ? idle_count : idle_count + LIMIT_W'(1);

  // Manchester decoding and frame completion.
  always_comb begin
    phase_next       = phase;
    bit_shift_next   = bit_shift;
    bit_count_next   = bit_count;
    idle_count_next  = idle_count;
    frame_end        = 1'b0;
    out_load         = 1'b0;
    out_kind_next    = EVT_FRAME;
    out_command_next = '0;
    out_address_next = '0;
    out_toggle_next  = 1'b0;

    if (pop) begin
      unique case (phase)
        P_IDLE: begin
          idle_count_next = '0;
          bit_count_next  = '0;
          bit_shift_next  = '0;
          phase_next      = P_SYNC;
        end
        P_SYNC: begin
          if (head_item.is_timeout) begin
            if (idle_inc > idle_limit) begin
              idle_count_next = '0;
              out_load        = 1'b1;
              out_kind_next   = EVT_NO_KEY;
            end else begin
              idle_count_next = idle_inc;
            end
          end else if (head_item.cls == CLS_FOUR) begin
            bit_shift_next = SHIFT_W'(3);
            bit_count_next = sat_add(bit_count, 2'd2);
            phase_next     = P_ONE;
          end
        end
        P_ONE: begin
          if (head_item.is_timeout) begin
            frame_end = 1'b1;
          end else begin
            unique case (head_item.cls)
              CLS_FOUR: begin
                bit_shift_next = {bit_shift[SHIFT_W-2:0], 1'b1};
                bit_count_next = sat_add(bit_count, 2'd1);
              end
              CLS_SIX: begin
                bit_shift_next = {bit_shift[SHIFT_W-3:0], 2'b00};
                bit_count_next = sat_add(bit_count, 2'd2);
                phase_next     = P_ZZ;
              end
              CLS_EIGHT: begin
                bit_shift_next = {bit_shift[SHIFT_W-3:0], 2'b01};
                bit_count_next = sat_add(bit_count, 2'd2);
              end
              default: begin
                phase_next = P_ERROR;
              end
            endcase
          end
        end
        P_ZZ: begin
          if (head_item.is_timeout) begin
            frame_end = 1'b1;
          end else if (head_item.cls == CLS_FOUR) begin
            bit_shift_next = {bit_shift[SHIFT_W-2:0], 1'b0};
            bit_count_next = sat_add(bit_count, 2'd1);
          end else if (head_item.cls == CLS_SIX) begin
            bit_shift_next = {bit_shift[SHIFT_W-2:0], 1'b1};
            bit_count_next = sat_add(bit_count, 2'd1);
            phase_next     = P_ONE;
          end else begin
            phase_next = P_ERROR;
          end
        end
        P_ERROR: begin
          if (head_item.is_timeout) begin
            phase_next = P_IDLE;
          end
        end
        default: begin
          phase_next = P_IDLE;
        end
      endcase
    end

    // A frame one bit short lost its trailing zero; a full frame is reported.
    if (frame_end) begin
      phase_next = P_IDLE;
      if (bit_count_next == SHORT_FRAME) begin
        bit_shift_next = {bit_shift_next[SHIFT_W-2:0], 1'b0};
        bit_count_next = FULL_FRAME;
      end
      if (bit_count_next == FULL_FRAME) begin
        out_load         = 1'b1;
        out_kind_next    = EVT_FRAME;
        out_command_next = bit_shift_next[COMMAND_W-1:0];
        out_address_next = bit_shift_next[COMMAND_W+ADDRESS_W-1:COMMAND_W];
        out_toggle_next  = bit_shift_next[COMMAND_W+ADDRESS_W];
      end
    end
  end

  // Decoder state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= P_IDLE;
      bit_shift  <= '0;
      bit_count  <= '0;
      idle_count <= '0;
    end else begin
      phase      <= phase_next;
      bit_shift  <= bit_shift_next;
      bit_count  <= bit_count_next;
      idle_count <= idle_count_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind    <= out_kind_next;
      out_command <= out_command_next;
      out_address <= out_address_next;
      out_toggle  <= out_toggle_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_nokey_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == EVT_NO_KEY) |->
      (out_command == '0 && out_address == '0 && out_toggle == 1'b0))
    else $error("no-key result carries nonzero frame fields");

  a_decode_has_start: assert property (@(posedge clk) disable iff (rst)
    (phase == P_ONE || phase == P_ZZ) |-> (bit_count >= COUNT_W'(2)))
    else $error("decoding phase entered without start bits");

  a_frame_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_kind_next == EVT_FRAME) |=> (phase == P_IDLE))
    else $error("decoder did not return to idle after a frame");
`endif

endmodule

// ===== src/rc5_pulse_width_decoder_core.sv =====
`timescale 1ns / 1ps

// Channel   | Group   | Contents
// ----------+---------+--------------------------------------------------------
// Widths in | s_axis  | tdata: width_ticks[15:0]; tuser: is_timeout
// Events out| m_axis  | tdata: command_code, address_code, toggle_bit, zero pad;
//           |         | tuser: event_kind
// Config    | cfg     | cfg_index selects the register, cfg_data is written
//
// A width passes through the front end in order: capture, rounding, the bit-serial
// restoring divider, and entry into the queue; a timeout skips the divider. The back
// end decodes one queued item per cycle while the event output is not stalled.
// Synchronous reset returns the decoder to idle and loads the register defaults.
// A stalled event output holds the back end; the queue lets the front keep going.

module rc5_pulse_width_decoder_core #(
  parameter int QUEUE_DEPTH = rc5pwd_pkg::QUEUE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [rc5pwd_pkg::WIDTH_W-1:0]       s_axis_tdata,   // [15:0] width_ticks
  input  logic                                 s_axis_tuser,   // [0] is_timeout
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [5:0] command_code, [10:6] address_code, [11] toggle_bit, [15:12] zero
  output logic [rc5pwd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                                 m_axis_tuser,   // [0] event_kind
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rc5pwd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [rc5pwd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import rc5pwd_pkg::*;

  logic [UNIT_W-1:0]    unit_ticks;
  logic [ROUND_W-1:0]   round_log2;
  logic [LIMIT_W-1:0]   idle_limit;
  logic                 push_valid;
  qitem_t               push_item;
  logic                 queue_full;
  logic                 pop;
  logic                 head_valid;
  qitem_t               head_item;
  logic                 out_kind;
  logic [COMMAND_W-1:0] out_command;
  logic [ADDRESS_W-1:0] out_address;
  logic                 out_toggle;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_ticks <= UNIT_TICKS_RESET;
      round_log2 <= ROUND_LOG2_RESET;
      idle_limit <= IDLE_LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_UNIT_TICKS: unit_ticks <= cfg_data[UNIT_W-1:0];
        REG_ROUND_LOG2: round_log2 <= cfg_data[ROUND_W-1:0];
        REG_IDLE_LIMIT: idle_limit <= cfg_data[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: rounding and division into width classes.
  rc5pwd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_timeout (s_axis_tuser),
    .in_width   (s_axis_tdata),
    .unit_ticks (unit_ticks),
    .round_log2 (round_log2),
    .push_valid (push_valid),
    .push_item  (push_item),
    .queue_full (queue_full)
  );

  // Queue of classified items.
  rc5pwd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push_valid),
    .push_item  (push_item),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  // Back end: Manchester decoding and event generation.
  rc5pwd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_item   (head_item),
    .pop         (pop),
    .idle_limit  (idle_limit),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_kind    (out_kind),
    .out_command (out_command),
    .out_address (out_address),
    .out_toggle  (out_toggle)
  );

  // Pack the event fields onto the output stream.
  assign m_axis_tuser = out_kind;
  assign m_axis_tdata = {{(OUT_DATA_W - COMMAND_W - ADDRESS_W - 1){1'b0}},
                         out_toggle, out_address, out_command};

endmodule
